// ===== rtl/pch_pkg.sv =====
package pch_pkg;

   localparam int NUM_BINS  = 95;
   localparam int BIN_IDX_W = $clog2(NUM_BINS);
   localparam int CMD_W     = 2;
   localparam int BYTE_W    = 8;
   localparam int VALUE_W   = 32;

   localparam logic [BYTE_W-1:0]    FIRST_PRINTABLE = 8'd32;
   localparam logic [BYTE_W-1:0]    LAST_PRINTABLE  = 8'd126;
   localparam logic [BIN_IDX_W-1:0] LAST_BIN        = BIN_IDX_W'(NUM_BINS - 1);

   typedef enum logic [CMD_W-1:0] {
      CMD_DATA   = 2'd0,
      CMD_END    = 2'd1,
      CMD_READ   = 2'd2,
      CMD_UNUSED = 2'd3
   } cmd_type;

   typedef enum logic {
      KIND_COUNT = 1'b0,
      KIND_BIN   = 1'b1
   } kind_type;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_INC  = 6'b000010,
      ST_MRD  = 6'b000100,
      ST_MWR  = 6'b001000,
      ST_GRD  = 6'b010000,
      ST_EMIT = 6'b100000
   } state_type;

endpackage

// ===== rtl/printable_char_histogram.sv =====
// Counts printable characters (codes 32 to 126) per connection in a local histogram and a
// running count, and merges the local bins into a global histogram when a connection ends.
// Both histograms sit in single-port-read RAMs and every bin update goes through one shared
// adder under a small sequencer, so one transaction is worked on at a time. A non-printable
// byte or an unused command needs no sequencer step; a printable byte takes a local bin
// read, then an add and write back; a global bin read takes a RAM read, then the emit step
// (an index past the last bin needs no RAM read); and an end of connection walks all 95
// bins, with one read step and one add-and-write step each, before the emit step.
// A command that returns a result also waits while the previous
// result is still held in the output register. Reset clears both histograms at once
// through per-bin valid bits, so no clearing pass follows reset. Counters are
// COUNTER_WIDTH bits wide and wrap; results show the low 32 bits.
module printable_char_histogram #(
   parameter int COUNTER_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [pch_pkg::CMD_W-1:0]      req_cmd,
   input  logic [pch_pkg::BYTE_W-1:0]     req_data_byte,
   input  logic [pch_pkg::BIN_IDX_W-1:0]  req_bin_index,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_result_kind,
   output logic [pch_pkg::VALUE_W-1:0]    rsp_result_value
);

   localparam int CW    = COUNTER_WIDTH;
   localparam int EXT_W = (CW > pch_pkg::VALUE_W) ? CW : pch_pkg::VALUE_W;
   localparam int IW    = pch_pkg::BIN_IDX_W;
   localparam int NB    = pch_pkg::NUM_BINS;

   pch_pkg::state_type state_ff, state_in;

   logic [IW-1:0]                idx_ff, idx_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [NB-1:0]                lvld_ff, lvld_in;
   logic [NB-1:0]                gvld_ff, gvld_in;
   logic                         lvld_q_ff, lvld_q_in;
   logic                         gvld_q_ff, gvld_q_in;
   logic                         pend_kind_ff, pend_kind_in;
   logic [pch_pkg::VALUE_W-1:0]  pend_value_ff, pend_value_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_kind_ff, rsp_kind_in;
   logic [pch_pkg::VALUE_W-1:0]  rsp_value_ff, rsp_value_in;

   logic                         req_accept;
   logic                         rsp_accept;
   logic                         printable;
   logic [pch_pkg::BYTE_W-1:0]   byte_off;
   logic                         read_in_range;

   logic                         lram_we, lram_re, gram_we, gram_re;
   logic [IW-1:0]                lram_raddr, gram_raddr;
   logic [CW-1:0]                lram_rdata, gram_rdata;
   logic [CW-1:0]                local_val, global_val;
   logic [CW-1:0]                add_a, add_b, add_sum;
   logic [EXT_W-1:0]             count_ext, gbin_ext;

   assign req_accept    = req_valid && !req_stall;
   assign rsp_accept    = rsp_valid_ff && !rsp_stall;
   assign req_stall     = (state_ff != pch_pkg::ST_IDLE);
   assign printable     = (req_data_byte >= pch_pkg::FIRST_PRINTABLE) &&
                          (req_data_byte <= pch_pkg::LAST_PRINTABLE);
   assign byte_off      = req_data_byte - pch_pkg::FIRST_PRINTABLE;
   assign read_in_range = (req_bin_index < IW'(NB));

   // A bin whose valid bit is clear has not been written since it was last cleared.
   assign local_val  = lvld_q_ff ? lram_rdata : '0;
   assign global_val = gvld_q_ff ? gram_rdata : '0;

   // The shared adder: increment of a local bin, or global plus local during the merge.
   assign add_a   = (state_ff == pch_pkg::ST_MWR) ? global_val : local_val;
   assign add_b   = (state_ff == pch_pkg::ST_MWR) ? local_val : CW'(1);
   assign add_sum = add_a + add_b;

   assign count_ext = EXT_W'(count_ff);
   assign gbin_ext  = EXT_W'(global_val);

   assign lram_re    = (req_accept && (req_cmd == pch_pkg::CMD_DATA) && printable) ||
                       (state_ff == pch_pkg::ST_MRD);
   assign lram_raddr = (state_ff == pch_pkg::ST_MRD) ? idx_ff : byte_off[IW-1:0];
   assign lram_we    = (state_ff == pch_pkg::ST_INC);
   assign gram_re    = (req_accept && (req_cmd == pch_pkg::CMD_READ) && read_in_range) ||
                       (state_ff == pch_pkg::ST_MRD);
   assign gram_raddr = (state_ff == pch_pkg::ST_MRD) ? idx_ff : req_bin_index;
   assign gram_we    = (state_ff == pch_pkg::ST_MWR);

   pch_ram #(
      .WIDTH (CW),
      .DEPTH (NB)
   ) u_local_ram (
      .clock   (clock),
      .wr_en   (lram_we),
      .wr_addr (idx_ff),
      .wr_data (add_sum),
      .rd_en   (lram_re),
      .rd_addr (lram_raddr),
      .rd_data (lram_rdata)
   );

   pch_ram #(
      .WIDTH (CW),
      .DEPTH (NB)
   ) u_global_ram (
      .clock   (clock),
      .wr_en   (gram_we),
      .wr_addr (idx_ff),
      .wr_data (add_sum),
      .rd_en   (gram_re),
      .rd_addr (gram_raddr),
      .rd_data (gram_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      lvld_in       = lvld_ff;
      gvld_in       = gvld_ff;
      lvld_q_in     = lvld_q_ff;
      gvld_q_in     = gvld_q_ff;
      pend_kind_in  = pend_kind_ff;
      pend_value_in = pend_value_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_value_in  = rsp_value_ff;

      if (rsp_accept) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         pch_pkg::ST_IDLE: begin
            if (req_accept) begin
               unique case (req_cmd)
                  pch_pkg::CMD_DATA: begin
                     if (printable) begin
                        idx_in    = byte_off[IW-1:0];
                        lvld_q_in = lvld_ff[byte_off[IW-1:0]];
                        state_in  = pch_pkg::ST_INC;
                     end
                  end
                  pch_pkg::CMD_END: begin
                     pend_kind_in  = pch_pkg::KIND_COUNT;
                     pend_value_in = count_ext[pch_pkg::VALUE_W-1:0];
                     count_in      = '0;
                     idx_in        = '0;
                     state_in      = pch_pkg::ST_MRD;
                  end
                  pch_pkg::CMD_READ: begin
                     pend_kind_in = pch_pkg::KIND_BIN;
                     if (read_in_range) begin
                        gvld_q_in = gvld_ff[req_bin_index];
                        state_in  = pch_pkg::ST_GRD;
                     end else begin
                        pend_value_in = '0;
                        state_in      = pch_pkg::ST_EMIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         pch_pkg::ST_INC: begin
            lvld_in[idx_ff] = 1'b1;
            count_in        = count_ff + CW'(1);
            state_in        = pch_pkg::ST_IDLE;
         end
         pch_pkg::ST_MRD: begin
            lvld_q_in = lvld_ff[idx_ff];
            gvld_q_in = gvld_ff[idx_ff];
            state_in  = pch_pkg::ST_MWR;
         end
         pch_pkg::ST_MWR: begin
            gvld_in[idx_ff] = 1'b1;
            lvld_in[idx_ff] = 1'b0;
            if (idx_ff == pch_pkg::LAST_BIN) begin
               state_in = pch_pkg::ST_EMIT;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = pch_pkg::ST_MRD;
            end
         end
         pch_pkg::ST_GRD: begin
            pend_value_in = gbin_ext[pch_pkg::VALUE_W-1:0];
            state_in      = pch_pkg::ST_EMIT;
         end
         pch_pkg::ST_EMIT: begin
            // The output register takes the result once the previous transaction has left.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = pend_kind_ff;
               rsp_value_in = pend_value_ff;
               state_in     = pch_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pch_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pch_pkg::ST_IDLE;
         count_ff     <= '0;
         lvld_ff      <= '0;
         gvld_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         lvld_ff      <= lvld_in;
         gvld_ff      <= gvld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      lvld_q_ff     <= lvld_q_in;
      gvld_q_ff     <= gvld_q_in;
      pend_kind_ff  <= pend_kind_in;
      pend_value_ff <= pend_value_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign rsp_result_value = rsp_value_ff;

   // The merge index never leaves the histogram.
   a_merge_idx_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == pch_pkg::ST_MRD) || (state_ff == pch_pkg::ST_MWR)) |->
         (idx_ff <= pch_pkg::LAST_BIN))
      else $error("merge index out of range");

   // Once the last bin has been merged, the local histogram is empty.
   a_merge_clears_local: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == pch_pkg::ST_MWR) && (idx_ff == pch_pkg::LAST_BIN)) |=> (lvld_ff == '0))
      else $error("local bins not cleared after merge");

   // An end of connection restarts the running count.
   a_end_clears_count: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_cmd == pch_pkg::CMD_END)) |=> (count_ff == '0))
      else $error("connection count not cleared");

   // A result only appears out of the emit state.
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == pch_pkg::ST_EMIT))
      else $error("result raised outside emit state");

endmodule

// ===== rtl/pch_ram.sv =====
module pch_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 95
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/sv/printable_char_histogram_tb.sv =====
`timescale 1ns / 100ps

module printable_char_histogram_tb;

   localparam int unsigned TARGET_ITEMS  = 1550;
   localparam int unsigned SETTLE_CYCLES = 250;
   localparam int unsigned CYCLE_LIMIT   = 1500000;

   typedef struct {
      pch_pkg::cmd_type                     cmd;
      logic [pch_pkg::BYTE_W-1:0]           data_byte;
      logic [pch_pkg::BIN_IDX_W-1:0]        bin_index;
      bit                                   hold_for_drain;
   } hist_request_type;

   typedef struct {
      pch_pkg::kind_type                    kind;
      logic [pch_pkg::VALUE_W-1:0]          value;
   } hist_result_type;

   logic                                 clock;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic [pch_pkg::CMD_W-1:0]            req_cmd = '0;
   logic [pch_pkg::BYTE_W-1:0]           req_data_byte = '0;
   logic [pch_pkg::BIN_IDX_W-1:0]        req_bin_index = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic                                 rsp_result_kind;
   logic [pch_pkg::VALUE_W-1:0]          rsp_result_value;

   hist_request_type                     pending_requests[$];
   hist_result_type                      awaited_results[$];
   logic [pch_pkg::VALUE_W-1:0]          local_tally [pch_pkg::NUM_BINS];
   logic [pch_pkg::VALUE_W-1:0]          global_tally [pch_pkg::NUM_BINS];
   logic [pch_pkg::VALUE_W-1:0]          printable_total = '0;

   int unsigned           counted_items = 0;
   bit                    drain_next = 1'b0;
   int unsigned           error_count = 0;
   int unsigned           cycle_count = 0;
   logic                  req_taken = 1'b0;
   int unsigned           send_gap = 0;
   int unsigned           send_calm = 0;
   int unsigned           stall_left = 0;
   int unsigned           stall_calm = 0;

   printable_char_histogram dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_data_byte    (req_data_byte),
      .req_bin_index    (req_bin_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_result_value (rsp_result_value)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Mostly short pauses, now and then a long one.
   function automatic int unsigned pick_pause();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [pch_pkg::BIN_IDX_W-1:0] pick_bin();
      if ($urandom_range(0, 9) == 0)
         return pch_pkg::BIN_IDX_W'($urandom_range(pch_pkg::NUM_BINS, 127));
      return pch_pkg::BIN_IDX_W'($urandom_range(0, pch_pkg::NUM_BINS - 1));
   endfunction

   function automatic void add_request(pch_pkg::cmd_type cmd,
                                       logic [pch_pkg::BYTE_W-1:0] data_byte,
                                       logic [pch_pkg::BIN_IDX_W-1:0] bin_index);
      hist_request_type item;
      item.cmd            = cmd;
      item.data_byte      = data_byte;
      item.bin_index      = bin_index;
      item.hold_for_drain = drain_next;
      drain_next          = 1'b0;
      pending_requests.push_back(item);
      counted_items++;
   endfunction

   function automatic logic [pch_pkg::BYTE_W-1:0] any_byte();
      return pch_pkg::BYTE_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [pch_pkg::BYTE_W-1:0] printable_byte();
      return pch_pkg::BYTE_W'($urandom_range(pch_pkg::FIRST_PRINTABLE,
                                             pch_pkg::LAST_PRINTABLE));
   endfunction

   // Tracks the local and global histograms and queues the result a command yields.
   function automatic void apply_histogram_cmd(pch_pkg::cmd_type cmd,
                                               logic [pch_pkg::BYTE_W-1:0] data_byte,
                                               logic [pch_pkg::BIN_IDX_W-1:0] bin_index);
      hist_result_type res;
      case (cmd)
         pch_pkg::CMD_DATA: begin
            if (data_byte >= pch_pkg::FIRST_PRINTABLE &&
                data_byte <= pch_pkg::LAST_PRINTABLE) begin
               local_tally[data_byte - pch_pkg::FIRST_PRINTABLE] += 1'b1;
               printable_total += 1'b1;
            end
         end
         pch_pkg::CMD_END: begin
            res.kind  = pch_pkg::KIND_COUNT;
            res.value = printable_total;
            awaited_results.push_back(res);
            for (int i = 0; i < pch_pkg::NUM_BINS; i++) begin
               global_tally[i] += local_tally[i];
               local_tally[i]   = '0;
            end
            printable_total = '0;
         end
         pch_pkg::CMD_READ: begin
            res.kind  = pch_pkg::KIND_BIN;
            res.value = (bin_index < pch_pkg::NUM_BINS) ? global_tally[bin_index] : '0;
            awaited_results.push_back(res);
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [pch_pkg::VALUE_W-1:0] wanted,
                                  logic [pch_pkg::VALUE_W-1:0] seen);
      $display("MISMATCH at cycle %0d, %s: expected 0x%08h, got 0x%08h",
               cycle_count, what, wanted, seen);
      error_count++;
   endtask

   // Request driver: a new transaction is presented only once the previous one has been taken.
   always @(negedge clock) begin : drive_requests
      logic             next_valid;
      hist_request_type item;
      if (!reset) begin
         next_valid = req_valid;
         if (req_valid && req_taken) begin
            next_valid = 1'b0;
            if (send_calm > 0) begin
               send_calm--;
               send_gap = 0;
            end else begin
               send_gap = pick_pause();
               if ($urandom_range(0, 199) == 0) send_calm = $urandom_range(40, 160);
            end
         end
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_requests.size() > 0 &&
                         (!pending_requests[0].hold_for_drain ||
                          awaited_results.size() == 0)) begin
               item          = pending_requests.pop_front();
               req_cmd       <= item.cmd;
               req_data_byte <= item.data_byte;
               req_bin_index <= item.bin_index;
               next_valid    = 1'b1;
            end
         end
         req_valid <= next_valid;
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (stall_calm > 0) begin
            stall_calm--;
         end else begin
            stall_left = pick_pause();
            if ($urandom_range(0, 199) == 0) stall_calm = $urandom_range(40, 160);
         end
      end
   end

   // Monitor: predicts on every accepted request and checks every accepted result.
   always @(posedge clock) begin : watch_results
      hist_result_type wanted;
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("printable_char_histogram verification failed");
         $finish;
      end
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall)
            apply_histogram_cmd(pch_pkg::cmd_type'(req_cmd), req_data_byte, req_bin_index);
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("result with nothing outstanding", '0, rsp_result_value);
            end else begin
               wanted = awaited_results.pop_front();
               if (rsp_result_kind !== wanted.kind)
                  report_mismatch("result_kind", pch_pkg::VALUE_W'(wanted.kind),
                                  pch_pkg::VALUE_W'(rsp_result_kind));
               if (rsp_result_value !== wanted.value)
                  report_mismatch("result_value", wanted.value, rsp_result_value);
            end
         end
      end
   end

   initial begin : run_test
      int unsigned     len;
      int unsigned     s;
      hist_result_type lost;
      for (int i = 0; i < pch_pkg::NUM_BINS; i++) begin
         local_tally[i]  = '0;
         global_tally[i] = '0;
      end

      // Directed opening: the printable edges, ignored bytes and commands, an empty
      // connection and reads beyond the last bin.
      add_request(pch_pkg::CMD_READ,   8'hA5, 7'd0);
      add_request(pch_pkg::CMD_DATA,   8'h00, 7'd127);
      add_request(pch_pkg::CMD_DATA,   8'd31, 7'd0);
      add_request(pch_pkg::CMD_DATA,   8'd32, 7'd0);
      add_request(pch_pkg::CMD_DATA,   8'd126, 7'd127);
      add_request(pch_pkg::CMD_DATA,   8'd127, 7'd0);
      add_request(pch_pkg::CMD_DATA,   8'hFF, 7'd0);
      add_request(pch_pkg::CMD_DATA,   8'd65, 7'd0);
      add_request(pch_pkg::CMD_DATA,   8'd65, 7'd0);
      add_request(pch_pkg::CMD_UNUSED, 8'hFF, 7'd127);
      add_request(pch_pkg::CMD_UNUSED, 8'd65, 7'd0);
      add_request(pch_pkg::CMD_END,    8'h00, 7'd0);
      drain_next = 1'b1;
      add_request(pch_pkg::CMD_READ,   8'h00, 7'd0);
      add_request(pch_pkg::CMD_READ,   8'hFF, pch_pkg::LAST_BIN);
      add_request(pch_pkg::CMD_READ,   8'h00, 7'd33);
      add_request(pch_pkg::CMD_READ,   8'h00, 7'd95);
      add_request(pch_pkg::CMD_READ,   8'hFF, 7'd127);
      add_request(pch_pkg::CMD_END,    8'hFF, 7'd127);
      add_request(pch_pkg::CMD_READ,   8'h00, 7'd33);
      add_request(pch_pkg::CMD_DATA,   8'd65, 7'd0);
      add_request(pch_pkg::CMD_END,    8'h00, 7'd0);
      add_request(pch_pkg::CMD_READ,   8'h00, 7'd33);

      // Random part: mostly whole connections with random content, the rest noise.
      while (counted_items < TARGET_ITEMS) begin
         if ($urandom_range(0, 99) < 85) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 250) : $urandom_range(0, 30);
            for (int k = 0; k < len; k++) begin
               s = $urandom_range(0, 99);
               if (s < 85)
                  add_request(pch_pkg::CMD_DATA, printable_byte(), pick_bin());
               else if (s < 93)
                  add_request(pch_pkg::CMD_DATA, any_byte(), pick_bin());
               else if (s < 98)
                  add_request(pch_pkg::CMD_READ, any_byte(), pick_bin());
               else
                  add_request(pch_pkg::CMD_UNUSED, any_byte(), pick_bin());
            end
            add_request(pch_pkg::CMD_END, any_byte(), pick_bin());
            repeat ($urandom_range(0, 3)) add_request(pch_pkg::CMD_READ, any_byte(), pick_bin());
         end else begin
            repeat ($urandom_range(1, 6))
               add_request(pch_pkg::cmd_type'($urandom_range(0, 3)), any_byte(),
                           pch_pkg::BIN_IDX_W'($urandom_range(0, 127)));
         end
         if ($urandom_range(0, 29) == 0) drain_next = 1'b1;
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_valid || awaited_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      while (awaited_results.size() != 0) begin
         lost = awaited_results.pop_front();
         report_mismatch("result never arrived", lost.value, '0);
      end

      if (error_count == 0)
         $display("printable_char_histogram verification clean");
      else
         $display("printable_char_histogram verification failed");
      $finish;
   end

endmodule
